/* rtl/efps_pkg.sv */
// Shared constants and types for the earliest finish element selector.
// No dependencies; imported by the lane and top level modules.
package efps_pkg;

	// Fixed field widths of the item and configuration interfaces
	localparam int IN_TIME_BITS = 48;
	localparam int EXEC_BITS    = 32;
	localparam int MASK_BITS    = 8;
	localparam int TYPE_BITS    = 2;
	localparam int MAX_TYPES    = 4;
	localparam int SEL_BITS     = 3;
	localparam int CMD_BITS     = 2;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;

	// Defaults for the top level parameters
	localparam int NUM_PE_DEF       = 8;
	localparam int NUM_PE_TYPES_DEF = 4;
	localparam int TIME_BITS_DEF    = 48;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_MASK = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TYPE_MAP    = 1'd1;

	// Item commands
	typedef enum logic [CMD_BITS-1:0] {
		CMD_SCHEDULE = 2'd0,
		CMD_RAISE    = 2'd1,
		CMD_SET      = 2'd2
	} cmd_t;

	// Control that travels with an item from lane stage to merge stage
	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic                running;
		logic [SEL_BITS-1:0] sel;
	} item_ctrl_t;

endpackage

/* rtl/efps_lane.sv */
// One processing element lane: start, end and wait of a task on that element.
// Depends on efps_pkg for the execution time width.
module efps_lane #(
	parameter int TIME_BITS = 48
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          eligible,
	input  logic [TIME_BITS-1:0]          ready,
	input  logic [TIME_BITS-1:0]          earliest,
	input  logic [efps_pkg::EXEC_BITS-1:0] exec,
	output logic                          eligible_s1,
	output logic [TIME_BITS-1:0]          start_s1,
	output logic [TIME_BITS-1:0]          end_s1,
	output logic [TIME_BITS-1:0]          wait_s1
);
	import efps_pkg::*;

	localparam int SUM_BITS = ((TIME_BITS > EXEC_BITS) ? TIME_BITS : EXEC_BITS) + 1;

	logic                 late;
	logic [TIME_BITS-1:0] start;
	logic [TIME_BITS-1:0] wait_t;
	logic [SUM_BITS-1:0]  sum;
	logic [TIME_BITS-1:0] end_t;

	// Start at the later of ready and earliest; wait is the gap to ready
	assign late   = earliest > ready;
	assign start  = late ? earliest : ready;
	assign wait_t = late ? (earliest - ready) : '0;

	// Add execution time, saturate at the largest time
	assign sum   = SUM_BITS'(start) + SUM_BITS'(exec);
	assign end_t = (|sum[SUM_BITS-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

	// Hold lane results for the merge stage
	always_ff @(posedge clk) begin
		if (load) begin
			eligible_s1 <= eligible;
			start_s1    <= start;
			end_s1      <= end_t;
			wait_s1     <= wait_t;
		end
	end

endmodule

/* rtl/efps_merge.sv */
// Compare tree that picks the lane with least end, then least wait, then lowest index.
// Depends on nothing beyond its parameters; fed by the efps_lane registers.
module efps_merge #(
	parameter int NUM_PE    = 8,
	parameter int TIME_BITS = 48
) (
	input  logic                 eligible [NUM_PE],
	input  logic [TIME_BITS-1:0] start_t  [NUM_PE],
	input  logic [TIME_BITS-1:0] end_t    [NUM_PE],
	input  logic [TIME_BITS-1:0] wait_t   [NUM_PE],
	output logic                 found,
	output logic [((NUM_PE > 1) ? $clog2(NUM_PE) : 1)-1:0] best_idx,
	output logic [TIME_BITS-1:0] best_start,
	output logic [TIME_BITS-1:0] best_end
);

	localparam int IDX_BITS = (NUM_PE > 1) ? $clog2(NUM_PE) : 1;
	localparam int LEAVES   = 2 ** $clog2(NUM_PE);
	localparam int NODES    = 2 * LEAVES - 1;

	logic                 node_v     [1:NODES];
	logic [IDX_BITS-1:0]  node_idx   [1:NODES];
	logic [TIME_BITS-1:0] node_start [1:NODES];
	logic [TIME_BITS-1:0] node_end   [1:NODES];
	logic [TIME_BITS-1:0] node_wait  [1:NODES];

	// Place lanes at the leaves, pad the rest as empty
	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < NUM_PE) begin : g_used
			assign node_v[LEAVES+i]     = eligible[i];
			assign node_idx[LEAVES+i]   = IDX_BITS'(i);
			assign node_start[LEAVES+i] = start_t[i];
			assign node_end[LEAVES+i]   = end_t[i];
			assign node_wait[LEAVES+i]  = wait_t[i];
		end else begin : g_pad
			assign node_v[LEAVES+i]     = 1'b0;
			assign node_idx[LEAVES+i]   = '0;
			assign node_start[LEAVES+i] = '0;
			assign node_end[LEAVES+i]   = '0;
			assign node_wait[LEAVES+i]  = '0;
		end
	end

	// Each node keeps the left child unless the right one is strictly better
	for (genvar k = 1; k < LEAVES; k++) begin : g_node
		logic take_r;
		assign take_r = node_v[2*k+1] && (!node_v[2*k]
			|| (node_end[2*k+1] < node_end[2*k])
			|| ((node_end[2*k+1] == node_end[2*k])
				&& (node_wait[2*k+1] < node_wait[2*k])));
		assign node_v[k]     = node_v[2*k] | node_v[2*k+1];
		assign node_idx[k]   = take_r ? node_idx[2*k+1]   : node_idx[2*k];
		assign node_start[k] = take_r ? node_start[2*k+1] : node_start[2*k];
		assign node_end[k]   = take_r ? node_end[2*k+1]   : node_end[2*k];
		assign node_wait[k]  = take_r ? node_wait[2*k+1]  : node_wait[2*k];
	end

	assign found      = node_v[1];
	assign best_idx   = node_idx[1];
	assign best_start = node_start[1];
	assign best_end   = node_end[1];

endmodule

/* rtl/earliest_finish_pe_selector.sv */
// Top level of the earliest finish element selector: ready times, lanes, merge, output.
// Depends on efps_pkg, efps_lane and efps_merge.
//
//   channel   handshake             payload
//   input     in_valid / in_stall   command, time_value, exec_time_type0..3,
//                                   allowed_mask, already_running, pe_select
//   output    out_valid / out_stall found, chosen_pe, start_time, end_time
//   config    cfg_we                cfg_index, cfg_data
//
// A new item is not taken until the lane stage has drained the last one; a result
// is written to the output register when its item drains from the lane stage.
// The ready time loop sets this: lanes register their results when an item is
// accepted, and the ready times are updated from the merge tree when it drains.
// in_stall is high while the lane stage holds an item; it drains when the
// output register is empty or being taken. Reset zeroes all ready times and
// sets every element active with type 0; no clearing pass is needed.
module earliest_finish_pe_selector #(
	parameter int NUM_PE       = efps_pkg::NUM_PE_DEF,
	parameter int NUM_PE_TYPES = efps_pkg::NUM_PE_TYPES_DEF,
	parameter int TIME_BITS    = efps_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [efps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [efps_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [efps_pkg::CMD_BITS-1:0]      command,
	input  logic [efps_pkg::IN_TIME_BITS-1:0]  time_value,
	input  logic [efps_pkg::EXEC_BITS-1:0]     exec_time_type0,
	input  logic [efps_pkg::EXEC_BITS-1:0]     exec_time_type1,
	input  logic [efps_pkg::EXEC_BITS-1:0]     exec_time_type2,
	input  logic [efps_pkg::EXEC_BITS-1:0]     exec_time_type3,
	input  logic [efps_pkg::MASK_BITS-1:0]     allowed_mask,
	input  logic                               already_running,
	input  logic [efps_pkg::SEL_BITS-1:0]      pe_select,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               found,
	output logic [efps_pkg::SEL_BITS-1:0]      chosen_pe,
	output logic [efps_pkg::IN_TIME_BITS-1:0]  start_time,
	output logic [efps_pkg::IN_TIME_BITS-1:0]  end_time
);
	import efps_pkg::*;

	localparam int IDX_BITS = (NUM_PE > 1) ? $clog2(NUM_PE) : 1;

	logic [MASK_BITS-1:0]     active_q;
	logic [2*MASK_BITS-1:0]   type_map_q;
	logic [TIME_BITS-1:0]     ready_q [NUM_PE];

	logic                     accept;
	logic                     drain;
	logic [TIME_BITS-1:0]     t_clip;
	logic [EXEC_BITS-1:0]     exec_by_type [MAX_TYPES];

	logic                     valid_s1;
	item_ctrl_t               ctrl_s1;
	logic [TIME_BITS-1:0]     t_s1;
	logic                     elig_s1  [NUM_PE];
	logic [TIME_BITS-1:0]     start_s1 [NUM_PE];
	logic [TIME_BITS-1:0]     end_s1   [NUM_PE];
	logic [TIME_BITS-1:0]     wait_s1  [NUM_PE];

	logic                     m_found;
	logic [IDX_BITS-1:0]      m_idx;
	logic [TIME_BITS-1:0]     m_start;
	logic [TIME_BITS-1:0]     m_end;
	logic                     sched_hit;
	logic                     set_hit;

	logic                     out_valid_q;
	logic                     found_q;
	logic [SEL_BITS-1:0]      chosen_q;
	logic [IN_TIME_BITS-1:0]  start_q;
	logic [IN_TIME_BITS-1:0]  end_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '1;
			type_map_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_MASK: active_q   <= cfg_data[MASK_BITS-1:0];
				CFG_TYPE_MAP:    type_map_q <= cfg_data[2*MASK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: one item in the lane stage at a time
	assign in_stall = valid_s1;
	assign accept   = in_valid && !valid_s1;
	assign drain    = valid_s1 && (!out_valid_q || !out_stall);

	// Clip the incoming time to the time range
	if (TIME_BITS >= IN_TIME_BITS) begin : g_clip_wide
		assign t_clip = TIME_BITS'(time_value);
	end else begin : g_clip_narrow
		assign t_clip = (|time_value[IN_TIME_BITS-1:TIME_BITS]) ? '1
			: time_value[TIME_BITS-1:0];
	end

	assign exec_by_type[0] = exec_time_type0;
	assign exec_by_type[1] = exec_time_type1;
	assign exec_by_type[2] = exec_time_type2;
	assign exec_by_type[3] = exec_time_type3;

	// Lanes: qualify each element and compute its times
	for (genvar i = 0; i < NUM_PE; i++) begin : g_lane
		logic                 elig;
		logic [TYPE_BITS-1:0] ty;
		if (i < MASK_BITS) begin : g_mapped
			assign ty   = type_map_q[TYPE_BITS*i +: TYPE_BITS];
			assign elig = active_q[i] && allowed_mask[i]
				&& (32'(ty) < NUM_PE_TYPES);
		end else begin : g_unmapped
			assign ty   = '0;
			assign elig = 1'b0;
		end

		efps_lane #(
			.TIME_BITS(TIME_BITS)
		) u_lane (
			.clk        (clk),
			.load       (accept),
			.eligible   (elig),
			.ready      (ready_q[i]),
			.earliest   (t_clip),
			.exec       (exec_by_type[ty]),
			.eligible_s1(elig_s1[i]),
			.start_s1   (start_s1[i]),
			.end_s1     (end_s1[i]),
			.wait_s1    (wait_s1[i])
		);
	end

	// Lane stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1.cmd     <= command;
			ctrl_s1.running <= already_running;
			ctrl_s1.sel     <= pe_select;
			t_s1            <= t_clip;
		end
	end

	// Merge stage
	efps_merge #(
		.NUM_PE   (NUM_PE),
		.TIME_BITS(TIME_BITS)
	) u_merge (
		.eligible  (elig_s1),
		.start_t   (start_s1),
		.end_t     (end_s1),
		.wait_t    (wait_s1),
		.found     (m_found),
		.best_idx  (m_idx),
		.best_start(m_start),
		.best_end  (m_end)
	);

	assign sched_hit = (cmd_t'(ctrl_s1.cmd) == CMD_SCHEDULE) && !ctrl_s1.running && m_found;
	assign set_hit   = (cmd_t'(ctrl_s1.cmd) == CMD_SET) && (32'(ctrl_s1.sel) < NUM_PE);

	// Ready times: update on drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PE; i++) begin
				ready_q[i] <= '0;
			end
		end else if (drain) begin
			for (int i = 0; i < NUM_PE; i++) begin
				if (cmd_t'(ctrl_s1.cmd) == CMD_RAISE) begin
					ready_q[i] <= start_s1[i];
				end else if (set_hit && (32'(ctrl_s1.sel) == i)) begin
					ready_q[i] <= t_s1;
				end else if (sched_hit && (m_idx == IDX_BITS'(i))) begin
					ready_q[i] <= m_end;
				end
			end
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: result of the drained item
	always_ff @(posedge clk) begin
		if (drain) begin
			found_q  <= 1'b0;
			chosen_q <= '0;
			start_q  <= '0;
			end_q    <= '0;
			if (cmd_t'(ctrl_s1.cmd) == CMD_SCHEDULE) begin
				if (ctrl_s1.running) begin
					start_q <= IN_TIME_BITS'(t_s1);
					end_q   <= IN_TIME_BITS'(t_s1);
				end else if (m_found) begin
					found_q  <= 1'b1;
					chosen_q <= SEL_BITS'(m_idx);
					start_q  <= IN_TIME_BITS'(m_start);
					end_q    <= IN_TIME_BITS'(m_end);
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign chosen_pe  = chosen_q;
	assign start_time = start_q;
	assign end_time   = end_q;

endmodule
